[sv/grks_pkg.sv]
// ----------------------------------------------------------------------------
// grks_pkg
// Shared types and codes for the greedy radius keypoint suppression block.
// ----------------------------------------------------------------------------
package grks_pkg;

  // Fixed field widths
  localparam int R2_W       = 34;
  localparam int MK_W       = 11;
  localparam int CC_W       = 16;
  localparam int ID_W       = 16;
  localparam int ST_W       = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 34;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS_SQ  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_KEEP   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CAND_COUNT = 2'd2;

  // Reset values of the configuration registers
  localparam logic [R2_W-1:0] RADIUS_SQ_RESET = 34'd25600;

  // Result status codes
  localparam logic [ST_W-1:0] ST_SUPPRESSED = 2'd0;
  localparam logic [ST_W-1:0] ST_KEPT       = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL       = 2'd2;

  // Back end sequencer states
  typedef enum logic [1:0] {
    B_IDLE,
    B_SCAN,
    B_DRAIN,
    B_DONE
  } back_state_t;

  // Classification of one request, made by the front end
  typedef struct packed {
    logic            locked;     // stored without a test
    logic            few;        // fewer than two candidates in the set
    logic [CC_W-1:0] remaining;  // candidates still to come, this one included
    logic [ID_W-1:0] id;
  } cls_t;

  // Configuration seen by the back end
  typedef struct packed {
    logic [R2_W-1:0] radius_sq;
    logic [MK_W-1:0] min_keep;
  } cfg_t;

endpackage

[sv/grks_front.sv]
// ----------------------------------------------------------------------------
// grks_front
// Accepts requests, holds the configuration registers and the candidate
// index, and classifies each request before it goes into the queue.
// ----------------------------------------------------------------------------
module grks_front #(
  parameter int COORD_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic                             q_full,
  input  logic                             mode,
  input  logic [COORD_BITS-1:0]            x_pos,
  input  logic [COORD_BITS-1:0]            y_pos,
  input  logic [grks_pkg::ID_W-1:0]        point_id,
  input  logic                             cfg_write,
  input  logic [grks_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [grks_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic                             push,
  output grks_pkg::cls_t                   cls,
  output logic [COORD_BITS-1:0]            x_out,
  output logic [COORD_BITS-1:0]            y_out,
  output grks_pkg::cfg_t                   cfg
);

  logic [grks_pkg::R2_W-1:0] radius_sq;
  logic [grks_pkg::MK_W-1:0] min_keep;
  logic [grks_pkg::CC_W-1:0] cand_count;
  logic [grks_pkg::CC_W-1:0] cand_index;
  logic                      accept;

  assign accept = start & ~q_full;
  assign push   = accept;

  // Configuration registers; a new candidate count restarts the index
  always_ff @(posedge clk) begin
    if (rst) begin
      radius_sq  <= grks_pkg::RADIUS_SQ_RESET;
      min_keep   <= '0;
      cand_count <= '0;
      cand_index <= '0;
    end else begin
      if (accept && mode && (cand_index != {grks_pkg::CC_W{1'b1}})) begin
        cand_index <= cand_index + grks_pkg::CC_W'(1);
      end
      if (cfg_write) begin
        case (cfg_index)
          grks_pkg::CFG_RADIUS_SQ: radius_sq <= cfg_data[grks_pkg::R2_W-1:0];
          grks_pkg::CFG_MIN_KEEP:  min_keep  <= cfg_data[grks_pkg::MK_W-1:0];
          grks_pkg::CFG_CAND_COUNT: begin
            cand_count <= cfg_data[grks_pkg::CC_W-1:0];
            cand_index <= '0;
          end
          default: ;
        endcase
      end
    end
  end

  // Classify the request
  always_comb begin
    cls.locked    = ~mode;
    cls.few       = (cand_count < grks_pkg::CC_W'(2));
    cls.remaining = (cand_count > cand_index) ? (cand_count - cand_index) : '0;
    cls.id        = point_id;
  end

  assign x_out         = x_pos;
  assign y_out         = y_pos;
  assign cfg.radius_sq = radius_sq;
  assign cfg.min_keep  = min_keep;

endmodule

[sv/grks_queue.sv]
// ----------------------------------------------------------------------------
// grks_queue
// Two-entry queue between the front end and the back end.
// ----------------------------------------------------------------------------
module grks_queue #(
  parameter int WIDTH = 82
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] head,
  output logic             not_empty,
  output logic             full
);

  logic [WIDTH-1:0] ent [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  // Store and release requests
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent[wr_ptr] <= push_data;
    end
  end

  assign head      = ent[rd_ptr];
  assign not_empty = (count != 2'd0);
  assign full      = (count == 2'd2);

endmodule

[sv/grks_back.sv]
// ----------------------------------------------------------------------------
// grks_back
// Carries out each request: forced keeps go straight to the store, other
// candidates scan the kept-point memory through a distance pipeline.
// ----------------------------------------------------------------------------
module grks_back #(
  parameter int MAX_KEPT   = 1024,
  parameter int COORD_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_valid,
  input  grks_pkg::cls_t              q_cls,
  input  logic [COORD_BITS-1:0]       q_x,
  input  logic [COORD_BITS-1:0]       q_y,
  input  grks_pkg::cfg_t              cfg,
  output logic                        pop,
  output logic                        done,
  output logic [grks_pkg::ID_W-1:0]   result_id,
  output logic [grks_pkg::ST_W-1:0]   status
);

  localparam int AW = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
  localparam int CW = $clog2(MAX_KEPT + 1);
  localparam int SQW = 2 * COORD_BITS;
  localparam int SW = SQW + 1;
  localparam int CMPW = (SW > grks_pkg::R2_W) ? SW : grks_pkg::R2_W;
  localparam int FW = ((CW > grks_pkg::CC_W) ? CW : grks_pkg::CC_W) + 1;

  grks_pkg::back_state_t state, state_next;

  logic [2*COORD_BITS-1:0] mem [MAX_KEPT];
  logic [2*COORD_BITS-1:0] rdata;

  logic [CW-1:0]             kept_count;
  logic [AW-1:0]             rd_addr;
  logic [COORD_BITS-1:0]     cur_x;
  logic [COORD_BITS-1:0]     cur_y;
  logic [grks_pkg::ID_W-1:0] cur_id;
  logic                      cur_direct;
  logic                      near;

  logic                      v1, v2, v3, v4;
  logic [COORD_BITS-1:0]     dx, dy;
  logic [SQW-1:0]            sqx, sqy;
  logic [SW-1:0]             dsum;

  logic                      forced;
  logic                      direct;
  logic                      rd_en;
  logic                      scan_last;
  logic                      finish;
  logic                      keep;
  logic                      store_full;
  logic                      wr_en;
  logic [COORD_BITS-1:0]     mx, my;

  // Keep without a test: locked point, small set, minimum count not met, or empty store
  assign forced = (cfg.min_keep != '0) &&
                  ((FW'(kept_count) + FW'(q_cls.remaining)) <= FW'(cfg.min_keep));
  assign direct = q_cls.locked | q_cls.few | forced | (kept_count == '0);

  assign scan_last  = ((CW'(rd_addr) + CW'(1)) == kept_count);
  assign keep       = cur_direct | ~near;
  assign store_full = (kept_count == CW'(MAX_KEPT));
  assign wr_en      = finish & keep & ~store_full;

  // Sequencer: next state and strobes
  always_comb begin
    state_next = state;
    pop        = 1'b0;
    rd_en      = 1'b0;
    finish     = 1'b0;
    case (state)
      grks_pkg::B_IDLE: begin
        if (q_valid) begin
          pop        = 1'b1;
          state_next = direct ? grks_pkg::B_DONE : grks_pkg::B_SCAN;
        end
      end
      grks_pkg::B_SCAN: begin
        rd_en = 1'b1;
        if (scan_last) begin
          state_next = grks_pkg::B_DRAIN;
        end
      end
      grks_pkg::B_DRAIN: begin
        if (!(v1 | v2 | v3 | v4)) begin
          state_next = grks_pkg::B_DONE;
        end
      end
      grks_pkg::B_DONE: begin
        finish     = 1'b1;
        state_next = grks_pkg::B_IDLE;
      end
      default: state_next = grks_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= grks_pkg::B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Latch the request and run the scan address
  always_ff @(posedge clk) begin
    if (pop) begin
      cur_x      <= q_x;
      cur_y      <= q_y;
      cur_id     <= q_cls.id;
      cur_direct <= direct;
      rd_addr    <= '0;
    end else if (rd_en) begin
      rd_addr <= rd_addr + AW'(1);
    end
  end

  // Kept-point memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[kept_count[AW-1:0]] <= {cur_x, cur_y};
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  assign mx = rdata[2*COORD_BITS-1:COORD_BITS];
  assign my = rdata[COORD_BITS-1:0];

  // Distance pipeline: difference, square, sum, compare
  always_ff @(posedge clk) begin
    dx   <= (mx >= cur_x) ? (mx - cur_x) : (cur_x - mx);
    dy   <= (my >= cur_y) ? (my - cur_y) : (cur_y - my);
    sqx  <= SQW'(dx) * SQW'(dx);
    sqy  <= SQW'(dy) * SQW'(dy);
    dsum <= SW'(sqx) + SW'(sqy);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      v4   <= 1'b0;
      near <= 1'b0;
    end else begin
      v1 <= rd_en;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      if (pop) begin
        near <= 1'b0;
      end else if (v4 && (CMPW'(dsum) <= CMPW'(cfg.radius_sq))) begin
        near <= 1'b1;
      end
    end
  end

  // Store count and result
  always_ff @(posedge clk) begin
    if (rst) begin
      kept_count <= '0;
      done       <= 1'b0;
    end else begin
      done <= finish;
      if (wr_en) begin
        kept_count <= kept_count + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      result_id <= cur_id;
      if (!keep) begin
        status <= grks_pkg::ST_SUPPRESSED;
      end else if (store_full) begin
        status <= grks_pkg::ST_FULL;
      end else begin
        status <= grks_pkg::ST_KEPT;
      end
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    kept_count <= CW'(MAX_KEPT))
    else $error("kept count beyond store depth");

  a_write_room: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (kept_count < CW'(MAX_KEPT)))
    else $error("store written while full");

  a_count_moves: assert property (@(posedge clk) disable iff (rst)
    (kept_count != $past(kept_count)) |-> $past(wr_en))
    else $error("kept count changed without a store write");

  a_idle_drained: assert property (@(posedge clk) disable iff (rst)
    (state == grks_pkg::B_IDLE) |-> !(v1 | v2 | v3 | v4))
    else $error("distance pipeline busy while idle");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (status == grks_pkg::ST_SUPPRESSED || status == grks_pkg::ST_KEPT ||
              status == grks_pkg::ST_FULL))
    else $error("undefined status code");
`endif

endmodule

[sv/greedy_radius_keypoint_suppression.sv]
// ----------------------------------------------------------------------------
// greedy_radius_keypoint_suppression
// Keeps keypoints that lie outside a radius of every point kept so far.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; a two-entry queue
// lets up to two requests wait while one is being worked on. Each request
// yields one result, shown for a single cycle with done high; the receiver
// cannot stall, so results must be captured when done is seen. With the back
// end idle, a locked point, or a candidate kept without a test (small set,
// minimum count not yet met, empty store), goes from the queue straight to
// the done state, from which done is registered. A tested candidate first
// scans the store: the kept-point memory has one read port and the scan
// reads one stored point per cycle into a four-stage distance pipeline,
// whose stages drain before the done state. Configuration writes are taken
// at once, and are meant for idle time.
// ----------------------------------------------------------------------------
module greedy_radius_keypoint_suppression #(
  parameter int MAX_KEPT   = 1024,
  parameter int COORD_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic                            mode,
  input  logic [COORD_BITS-1:0]           x_pos,
  input  logic [COORD_BITS-1:0]           y_pos,
  input  logic [grks_pkg::ID_W-1:0]       point_id,
  input  logic                            cfg_write,
  input  logic [grks_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [grks_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                            done,
  output logic [grks_pkg::ID_W-1:0]       result_id,
  output logic [grks_pkg::ST_W-1:0]       status
);

  localparam int CLS_W = $bits(grks_pkg::cls_t);
  localparam int QW    = CLS_W + 2 * COORD_BITS;

  logic                  q_full;
  logic                  q_valid;
  logic                  push;
  logic                  pop;
  grks_pkg::cls_t        front_cls;
  logic [COORD_BITS-1:0] front_x, front_y;
  grks_pkg::cfg_t        cfg;
  logic [QW-1:0]         q_head;
  grks_pkg::cls_t        head_cls;
  logic [COORD_BITS-1:0] head_x, head_y;

  assign busy = q_full;

  // Accept and classify
  grks_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .q_full   (q_full),
    .mode     (mode),
    .x_pos    (x_pos),
    .y_pos    (y_pos),
    .point_id (point_id),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .push     (push),
    .cls      (front_cls),
    .x_out    (front_x),
    .y_out    (front_y),
    .cfg      (cfg)
  );

  // Hold classified requests
  grks_queue #(
    .WIDTH(QW)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data({front_cls, front_x, front_y}),
    .pop      (pop),
    .head     (q_head),
    .not_empty(q_valid),
    .full     (q_full)
  );

  assign head_cls = q_head[QW-1 -: CLS_W];
  assign head_x   = q_head[2*COORD_BITS-1:COORD_BITS];
  assign head_y   = q_head[COORD_BITS-1:0];

  // Test and store
  grks_back #(
    .MAX_KEPT  (MAX_KEPT),
    .COORD_BITS(COORD_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_cls    (head_cls),
    .q_x      (head_x),
    .q_y      (head_y),
    .cfg      (cfg),
    .pop      (pop),
    .done     (done),
    .result_id(result_id),
    .status   (status)
  );

endmodule
